/* rtl/trds_pkg.sv */
// Shared types and constants for the task ready/delay scheduler.
// Request and response payloads, the slot record kept in memory, and codes.
// No dependencies.
`default_nettype none

package trds_pkg;

  localparam int DEF_TASK_SLOTS  = 16;
  localparam int DEF_PRIO_LEVELS = 32;

  // Links hold a slot number or the null value TASK_SLOTS, up to 127 slots.
  localparam int LINK_W = 7;
  localparam int PRIO_W = 5;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DELAY   = 3'd1,
    OP_SUSPEND = 3'd2,
    OP_RESUME  = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_NO_SLOT = 2'd1,
    STS_IGNORED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    TS_SUSP  = 2'd0,
    TS_READY = 2'd1,
    TS_BLOCK = 2'd2
  } task_state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  task_slot;
    logic [5:0]  prio;
    logic [31:0] ticks;
    logic [3:0]  running_slot;
    logic        running_valid;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  new_slot;
    logic [31:0] ready_bitmap;
    logic        preempt_request;
    logic        yield_request;
    logic [15:0] woken_mask;
    logic [31:0] tick_total;
  } rsp_t;

  // One record per task slot. The delay is kept as an absolute wake time.
  typedef struct packed {
    logic [1:0]        state;
    logic [PRIO_W-1:0] prio;
    logic [LINK_W-1:0] rnext;
    logic [LINK_W-1:0] rprev;
    logic [LINK_W-1:0] dnext;
    logic [LINK_W-1:0] dprev;
    logic [31:0]       wake;
  } slot_rec_t;

  typedef struct packed {
    logic [LINK_W-1:0] head;
    logic [LINK_W-1:0] tail;
  } queue_ent_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } eng_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_sts_t;

endpackage

`default_nettype wire

/* rtl/trds_engine.sv */
// Command sequencer for the scheduler: slot record memory, queue head/tail
// memory and the list walks over them. Depends on trds_pkg.
`default_nettype none

module trds_engine
  import trds_pkg::*;
#(
  parameter int TASK_SLOTS  = DEF_TASK_SLOTS,
  parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire eng_ctl_t ctl,
  input  wire req_t     req,
  output eng_sts_t      sts,
  output rsp_t          result
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam int PW = $clog2(PRIO_LEVELS);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(TASK_SLOTS);

  typedef enum logic [27:0] {
    S_IDLE = 28'h0000001, S_RUN  = 28'h0000002, S_TGT  = 28'h0000004,
    S_A0   = 28'h0000008, S_A1   = 28'h0000010, S_A2   = 28'h0000020,
    S_R0   = 28'h0000040, S_R1   = 28'h0000080, S_R2   = 28'h0000100,
    S_R3   = 28'h0000200, S_R4   = 28'h0000400, S_R5   = 28'h0000800,
    S_D0   = 28'h0001000, S_D1   = 28'h0002000, S_D2   = 28'h0004000,
    S_D3   = 28'h0008000, S_I0   = 28'h0010000, S_I1   = 28'h0020000,
    S_I2   = 28'h0040000, S_I3   = 28'h0080000, S_I4   = 28'h0100000,
    S_I5   = 28'h0200000, S_TW0  = 28'h0400000, S_TW1  = 28'h0800000,
    S_TW2  = 28'h1000000, S_TW3  = 28'h2000000, S_WB   = 28'h4000000,
    S_FIN  = 28'h8000000
  } state_t;

  state_t st, after;

  // Memories, one read port with registered data and one write port each.
  slot_rec_t  smem [TASK_SLOTS];
  queue_ent_t qmem [PRIO_LEVELS];
  slot_rec_t  sm_q, sm_wdata;
  queue_ent_t qm_q, qm_wdata;
  logic [SW-1:0] sm_raddr, sm_waddr;
  logic [PW-1:0] qm_addr;
  logic sm_we, qm_we;

  always_ff @(posedge clk) begin
    if (sm_we) smem[sm_waddr] <= sm_wdata;
    sm_q <= smem[sm_raddr];
  end

  always_ff @(posedge clk) begin
    if (qm_we) qmem[qm_addr] <= qm_wdata;
    qm_q <= qmem[qm_addr];
  end

  // Control state.
  logic [TASK_SLOTS-1:0] used;
  logic [31:0]           prio_bitmap;
  logic [LINK_W-1:0]     delay_head;
  logic [31:0]           tick_counter;

  // Per-request working registers.
  req_t              rq;
  slot_rec_t         rec;
  queue_ent_t        qe;
  logic [SW-1:0]     sidx;
  logic [LINK_W-1:0] pv, cur;
  logic [PRIO_W-1:0] rs_prio;
  logic [1:0]        status;
  logic [3:0]        new_slot;
  logic              preempt, yield_req;
  logic [15:0]       woken;

  logic [LINK_W-1:0] tslot, rslot, s_link, in_rslot;
  logic              slot_ok, run_ok, is_running;
  logic              free_found;
  logic [SW-1:0]     free_idx;
  logic [PRIO_W-1:0] clamped;
  queue_ent_t        qcur;
  logic [31:0]       rem_cur;
  slot_rec_t         rec_tgt;

  assign tslot      = LINK_W'(rq.task_slot);
  assign rslot      = LINK_W'(rq.running_slot);
  assign in_rslot   = LINK_W'(req.running_slot);
  assign s_link     = LINK_W'(sidx);
  assign slot_ok    = (tslot < NIL) && used[tslot[SW-1:0]];
  assign run_ok     = rq.running_valid && (rslot < NIL) && used[rslot[SW-1:0]];
  assign is_running = run_ok && slot_ok && (tslot == rslot);
  assign clamped    = (7'(rq.prio) >= 7'(PRIO_LEVELS)) ? PRIO_W'(PRIO_LEVELS - 1)
                                                     : rq.prio[PRIO_W-1:0];
  assign qcur       = prio_bitmap[rec.prio] ? qm_q : '{head: NIL, tail: NIL};
  assign rem_cur    = sm_q.wake - tick_counter;
  assign qm_addr    = rec.prio[PW-1:0];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Working record of the addressed slot as the command leaves it.
  always_comb begin
    rec_tgt = sm_q;
    case (rq.op)
      OP_CREATE: rec_tgt = '{state: TS_READY, prio: clamped, rnext: NIL, rprev: NIL,
                             dnext: NIL, dprev: NIL, wake: '0};
      OP_DELAY: begin
        rec_tgt.state = TS_BLOCK;
        rec_tgt.wake  = tick_counter + rq.ticks;
      end
      OP_SUSPEND: rec_tgt.state = TS_SUSP;
      OP_RESUME:  rec_tgt.state = TS_READY;
      default: ;
    endcase
  end

  // Memory port control by state.
  always_comb begin
    sm_we    = 1'b0;
    sm_waddr = sidx;
    sm_wdata = rec;
    sm_raddr = '0;
    qm_we    = 1'b0;
    qm_wdata = qe;
    case (st)
      S_IDLE: sm_raddr = in_rslot[SW-1:0];
      S_RUN:  sm_raddr = tslot[SW-1:0];
      S_A1: begin
        qm_we    = 1'b1;
        qm_wdata = (qcur.tail == NIL) ? '{head: s_link, tail: s_link}
                                      : '{head: qcur.head, tail: s_link};
        sm_raddr = qcur.tail[SW-1:0];
      end
      S_A2: begin
        sm_we          = 1'b1;
        sm_waddr       = pv[SW-1:0];
        sm_wdata       = sm_q;
        sm_wdata.rnext = s_link;
      end
      S_R1: sm_raddr = rec.rprev[SW-1:0];
      S_R2: begin
        sm_we          = 1'b1;
        sm_waddr       = rec.rprev[SW-1:0];
        sm_wdata       = sm_q;
        sm_wdata.rnext = rec.rnext;
      end
      S_R3: sm_raddr = rec.rnext[SW-1:0];
      S_R4: begin
        sm_we          = 1'b1;
        sm_waddr       = rec.rnext[SW-1:0];
        sm_wdata       = sm_q;
        sm_wdata.rprev = rec.rprev;
      end
      S_R5: qm_we = 1'b1;
      S_D0: sm_raddr = rec.dprev[SW-1:0];
      S_D1: begin
        sm_we          = 1'b1;
        sm_waddr       = rec.dprev[SW-1:0];
        sm_wdata       = sm_q;
        sm_wdata.dnext = rec.dnext;
      end
      S_D2: sm_raddr = rec.dnext[SW-1:0];
      S_D3: begin
        sm_we          = 1'b1;
        sm_waddr       = rec.dnext[SW-1:0];
        sm_wdata       = sm_q;
        sm_wdata.dprev = rec.dprev;
      end
      S_I0: sm_raddr = cur[SW-1:0];
      S_I2: sm_raddr = pv[SW-1:0];
      S_I3: begin
        sm_we          = 1'b1;
        sm_waddr       = pv[SW-1:0];
        sm_wdata       = sm_q;
        sm_wdata.dnext = s_link;
      end
      S_I4: sm_raddr = cur[SW-1:0];
      S_I5: begin
        sm_we          = 1'b1;
        sm_waddr       = cur[SW-1:0];
        sm_wdata       = sm_q;
        sm_wdata.dprev = s_link;
      end
      S_TW0: sm_raddr = delay_head[SW-1:0];
      S_TW3, S_WB: sm_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      after        <= S_WB;
      used         <= '0;
      prio_bitmap  <= '0;
      delay_head   <= NIL;
      tick_counter <= '0;
    end else begin
      case (st)
        S_IDLE: begin
          if (ctl.start) begin
            rq        <= req;
            status    <= STS_DONE;
            new_slot  <= '0;
            preempt   <= 1'b0;
            yield_req <= 1'b0;
            woken     <= '0;
            st        <= S_RUN;
          end
        end
        S_RUN: begin
          rs_prio <= sm_q.prio;
          st      <= S_TGT;
        end
        S_TGT: begin
          sidx <= (rq.op == OP_CREATE) ? free_idx : tslot[SW-1:0];
          rec  <= rec_tgt;
          case (rq.op)
            OP_CREATE: begin
              if (!free_found) begin
                status <= STS_NO_SLOT;
                st     <= S_FIN;
              end else begin
                used[free_idx] <= 1'b1;
                new_slot       <= 4'(LINK_W'(free_idx));
                preempt        <= run_ok && (clamped > rs_prio);
                after          <= S_WB;
                st             <= S_A0;
              end
            end
            OP_DELAY: begin
              if (!slot_ok || sm_q.state != TS_READY) begin
                status <= STS_IGNORED;
                st     <= S_FIN;
              end else begin
                yield_req <= is_running;
                if (rq.ticks == '0) begin
                  st <= S_FIN;
                end else begin
                  after <= S_I0;
                  st    <= S_R0;
                end
              end
            end
            OP_SUSPEND: begin
              if (!slot_ok) begin
                status <= STS_IGNORED;
                st     <= S_FIN;
              end else begin
                yield_req <= is_running;
                after     <= S_WB;
                if (sm_q.state == TS_READY) st <= S_R0;
                else if (sm_q.state == TS_BLOCK) st <= S_D0;
                else st <= S_WB;
              end
            end
            OP_RESUME: begin
              if (!slot_ok || sm_q.state != TS_SUSP) begin
                status <= STS_IGNORED;
                st     <= S_FIN;
              end else begin
                preempt <= run_ok && (sm_q.prio > rs_prio);
                after   <= S_WB;
                st      <= S_A0;
              end
            end
            OP_TICK: begin
              tick_counter <= tick_counter + 32'd1;
              st           <= S_TW0;
            end
            default: begin
              status <= STS_IGNORED;
              st     <= S_FIN;
            end
          endcase
        end
        // Append to the tail of the ready queue of rec.prio.
        S_A0: st <= S_A1;
        S_A1: begin
          rec.rnext <= NIL;
          rec.rprev <= qcur.tail;
          pv        <= qcur.tail;
          if (qcur.tail == NIL) begin
            prio_bitmap[rec.prio] <= 1'b1;
            st <= after;
          end else begin
            st <= S_A2;
          end
        end
        S_A2: st <= after;
        // Unlink from the ready queue.
        S_R0: st <= S_R1;
        S_R1: begin
          qe <= '{head: (rec.rprev == NIL) ? rec.rnext : qm_q.head, tail: qm_q.tail};
          st <= (rec.rprev == NIL) ? S_R3 : S_R2;
        end
        S_R2: st <= S_R3;
        S_R3: begin
          if (rec.rnext == NIL) begin
            qe.tail <= rec.rprev;
            st      <= S_R5;
          end else begin
            st <= S_R4;
          end
        end
        S_R4: st <= S_R5;
        S_R5: begin
          if (qe.head == NIL) prio_bitmap[rec.prio] <= 1'b0;
          rec.rnext <= NIL;
          rec.rprev <= NIL;
          st        <= after;
        end
        // Unlink from the delay list.
        S_D0: begin
          if (rec.dprev == NIL) begin
            delay_head <= rec.dnext;
            st         <= S_D2;
          end else begin
            st <= S_D1;
          end
        end
        S_D1: st <= S_D2;
        S_D2: begin
          if (rec.dnext == NIL) begin
            rec.dprev <= NIL;
            st        <= after;
          end else begin
            st <= S_D3;
          end
        end
        S_D3: begin
          rec.dnext <= NIL;
          rec.dprev <= NIL;
          st        <= after;
        end
        // Sorted insert: skip entries whose remaining time is not larger.
        S_I0: st <= (cur == NIL) ? S_I2 : S_I1;
        S_I1: begin
          if (rem_cur <= rq.ticks) begin
            pv  <= cur;
            cur <= sm_q.dnext;
            st  <= S_I0;
          end else begin
            st <= S_I2;
          end
        end
        S_I2: begin
          rec.dnext <= cur;
          rec.dprev <= pv;
          if (pv == NIL) begin
            delay_head <= s_link;
            st         <= S_I4;
          end else begin
            st <= S_I3;
          end
        end
        S_I3: st <= S_I4;
        S_I4: st <= (cur == NIL) ? S_WB : S_I5;
        S_I5: st <= S_WB;
        // Tick: wake expired tasks from the head of the delay list.
        S_TW0: st <= (delay_head == NIL) ? S_FIN : S_TW1;
        S_TW1: begin
          if (sm_q.wake == tick_counter) begin
            sidx  <= delay_head[SW-1:0];
            rec   <= sm_q;
            woken <= woken | (16'd1 << delay_head);
            after <= S_TW2;
            st    <= S_D0;
          end else begin
            st <= S_FIN;
          end
        end
        S_TW2: begin
          rec.state <= TS_READY;
          after     <= S_TW3;
          st        <= S_A0;
        end
        S_TW3: st <= S_TW0;
        S_WB:  st <= S_FIN;
        S_FIN: if (ctl.out_free) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
      if (st == S_IDLE || st == S_TGT) begin
        pv  <= NIL;
        cur <= delay_head;
      end
    end
  end

  assign sts.idle = (st == S_IDLE);
  assign sts.done = (st == S_FIN) && ctl.out_free;

  assign result.status          = status;
  assign result.new_slot        = new_slot;
  assign result.ready_bitmap    = prio_bitmap;
  assign result.preempt_request = preempt;
  assign result.yield_request   = yield_req;
  assign result.woken_mask      = woken;
  assign result.tick_total      = tick_counter;

endmodule

`default_nettype wire

/* rtl/task_ready_delay_scheduler_unit.sv */
// Top level of the task ready/delay scheduler: request intake, response
// register and the command engine. Depends on trds_pkg and trds_engine.
//
//   channel   direction  handshake             payload
//   request   in         req_valid/req_stall   req (req_t)
//   response  out        rsp_valid/rsp_stall   rsp (rsp_t)
//
// One request is worked at a time. From acceptance to the response, a delay
// takes longer the more delay-list entries it passes, and a tick the more
// tasks it wakes; the engine goes back to idle after each request. The slot
// record memory port, read once per entry a delay walk passes and read and
// written once per neighbour whose link is updated, sets the pace.
// After reset the block is idle and takes a request at once; no memory sweep.
// A finished response waits in its register while the next request starts.
`default_nettype none

module task_ready_delay_scheduler_unit
  import trds_pkg::*;
#(
  parameter int TASK_SLOTS  = DEF_TASK_SLOTS,
  parameter int PRIO_LEVELS = DEF_PRIO_LEVELS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  eng_ctl_t ctl;
  eng_sts_t sts;
  rsp_t     result;

  assign req_stall    = !sts.idle;
  assign ctl.start    = req_valid && sts.idle;
  assign ctl.out_free = !rsp_valid || !rsp_stall;

  trds_engine #(
    .TASK_SLOTS (TASK_SLOTS),
    .PRIO_LEVELS(PRIO_LEVELS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .req   (req),
    .sts   (sts),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (sts.done) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) rsp <= result;
  end

endmodule

`default_nettype wire

/* rtl/trds_checker.sv */
// Port-level checks for the task ready/delay scheduler, bound to the top.
// Depends on trds_pkg and task_ready_delay_scheduler_unit.
`default_nettype none

module trds_checker
  import trds_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status != 2'd3)
    else $error("undefined status code");

  // A refused command has no side requests and wakes nothing.
  a_refused_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STS_DONE |->
      !rsp.preempt_request && !rsp.yield_request && rsp.woken_mask == 16'd0)
    else $error("refused command raised a request");

  // Preempt comes from create or resume, yield from delay or suspend.
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.preempt_request && rsp.yield_request))
    else $error("preempt and yield in one response");

  // The engine takes no new request while a request is being worked.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request accepted while busy");

endmodule

bind task_ready_delay_scheduler_unit trds_checker u_trds_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

`default_nettype wire
